FILE: sv/tfd_pkg.sv
`timescale 1ns / 1ps

package tfd_pkg;

  // Frame header bytes and tag placement within the frame.
  localparam logic [7:0] HDR_BYTE0  = 8'h44;
  localparam logic [7:0] HDR_BYTE1  = 8'h16;
  localparam int unsigned TAG_OFFSET = 10;
  localparam int unsigned TAG_STRIDE = 22;
  localparam int unsigned TAG_LEN    = 12;
  localparam int unsigned TAG_HIGH_BYTES = 4;

  localparam int unsigned TAG_HIGH_W = 32;
  localparam int unsigned TAG_LOW_W  = 64;
  localparam int unsigned TAG_W      = TAG_HIGH_W + TAG_LOW_W;

  // Byte counter within one tag slot of the frame, and the tag index.
  localparam int unsigned STRIDE_W = 5;
  localparam int unsigned TAG_IDX_W = 8;

  typedef enum logic [1:0] {
    OUT_STORED    = 2'd0,
    OUT_DUPLICATE = 2'd1,
    OUT_FULL      = 2'd2,
    OUT_LOCKED    = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_e;

endpackage

FILE: sv/tfd_ram.sv
`timescale 1ns / 1ps

module tfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tag_frame_dedup_table.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+------------------------------------------
// input     | in        | in_valid_i / in_ready_o | rx_byte_i, frame_start_i
// result    | out       | out_valid_o/ out_ready_i| tag_id_high_o, tag_id_low_o, outcome_o,
//           |           |                         | slot_index_o, entry_count_o
// config    | in        | cfg_we_i (no wait)      | cfg_wdata_i (table lock)
//
// A byte that completes no tag leaves the sequencer idle, so such bytes stream back to back.
// A byte that completes a tag starts a scan of the tag memory: one read per stored entry,
// ending early on a match (a locked table skips the scan), then the result register is
// loaded; no byte is taken until the sequencer returns to idle, and the single read port
// of the tag memory bounds the scan. The result stage holds one word; a scan that finishes
// while that word is still unclaimed waits before loading it. Reset clears all control
// state; the tag memory is not cleared, since only entries below the count are read.

module tag_frame_dedup_table #(
  parameter int unsigned TABLE_DEPTH = 12,
  parameter int unsigned FRAME_BYTES = 128,
  localparam int unsigned SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           frame_start_i,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tfd_pkg::TAG_HIGH_W-1:0] tag_id_high_o,
  output logic [tfd_pkg::TAG_LOW_W-1:0]  tag_id_low_o,
  output logic [1:0]                     outcome_o,
  output logic [SLOT_W-1:0]              slot_index_o,
  output logic [CNT_W-1:0]               entry_count_o
);

  import tfd_pkg::*;

  localparam int unsigned POS_W = $clog2(FRAME_BYTES + 1);

  // Frame parsing state.
  logic [POS_W-1:0]      pos_q, pos_d;
  logic                  fvalid_q, fvalid_d;
  logic [7:0]            tags_q, tags_d;
  logic [STRIDE_W-1:0]   k_q, k_d;
  logic [TAG_IDX_W-1:0]  idx_q, idx_d;
  logic [TAG_HIGH_W-1:0] ah_q, ah_d;
  logic [TAG_LOW_W-1:0]  al_q, al_d;

  // Table and scan state.
  state_e                state_q, state_d;
  logic                  locked_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic                  cmp_valid_q, cmp_valid_d;
  logic [SLOT_W-1:0]     cmp_ptr_q, cmp_ptr_d;
  outcome_e              res_outcome_q, res_outcome_d;
  logic [SLOT_W-1:0]     res_slot_q, res_slot_d;

  // Result register.
  logic                  out_valid_q, out_valid_d;
  logic [TAG_HIGH_W-1:0] out_high_q;
  logic [TAG_LOW_W-1:0]  out_low_q;
  outcome_e              out_outcome_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic [CNT_W-1:0]      out_count_q;
  logic                  out_load;

  // Tag memory port signals.
  logic                  ram_we, ram_re;
  logic [TAG_W-1:0]      ram_rdata;

  // Values after an optional start mark has restarted the frame.
  logic [POS_W-1:0]      pos_e;
  logic                  fvalid_e;
  logic [7:0]            tags_e;
  logic [STRIDE_W-1:0]   k_e;
  logic [TAG_IDX_W-1:0]  idx_e;
  logic [TAG_HIGH_W-1:0] ah_e;
  logic [TAG_LOW_W-1:0]  al_e;
  logic                  accept, complete, match;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pos_e    = frame_start_i ? '0 : pos_q;
    fvalid_e = frame_start_i ? 1'b0 : fvalid_q;
    tags_e   = frame_start_i ? '0 : tags_q;
    k_e      = frame_start_i ? '0 : k_q;
    idx_e    = frame_start_i ? '0 : idx_q;
    ah_e     = frame_start_i ? '0 : ah_q;
    al_e     = frame_start_i ? '0 : al_q;
  end

  // Byte parser. Tag slot position is tracked by a wrapping counter rather than a division.
  always_comb begin
    pos_d    = pos_q;
    fvalid_d = fvalid_q;
    tags_d   = tags_q;
    k_d      = k_q;
    idx_d    = idx_q;
    ah_d     = ah_q;
    al_d     = al_q;
    complete = 1'b0;
    if (accept) begin
      pos_d    = pos_e;
      fvalid_d = fvalid_e;
      tags_d   = tags_e;
      k_d      = k_e;
      idx_d    = idx_e;
      ah_d     = ah_e;
      al_d     = al_e;
      if (pos_e < POS_W'(FRAME_BYTES)) begin
        pos_d = pos_e + POS_W'(1);
        if (pos_e == POS_W'(0)) begin
          fvalid_d = (rx_byte_i == HDR_BYTE0);
        end else if (pos_e == POS_W'(1)) begin
          fvalid_d = fvalid_e && (rx_byte_i == HDR_BYTE1);
        end else if (pos_e == POS_W'(2)) begin
          tags_d = rx_byte_i;
        end else if (pos_e >= POS_W'(TAG_OFFSET)) begin
          if (k_e < STRIDE_W'(TAG_HIGH_BYTES)) begin
            ah_d = {ah_e[TAG_HIGH_W-9:0], rx_byte_i};
          end else if (k_e < STRIDE_W'(TAG_LEN)) begin
            al_d = {al_e[TAG_LOW_W-9:0], rx_byte_i};
          end
          if (k_e == STRIDE_W'(TAG_STRIDE - 1)) begin
            k_d   = '0;
            idx_d = idx_e + TAG_IDX_W'(1);
          end else begin
            k_d = k_e + STRIDE_W'(1);
          end
          complete = (k_e == STRIDE_W'(TAG_LEN - 1)) && fvalid_e && (idx_e < tags_e);
        end
      end
    end
  end

  // Table sequencer: the scan issues one read per cycle and compares the word read
  // in the previous cycle, stopping early on a match.
  assign match = cmp_valid_q && (ram_rdata == {ah_q, al_q});

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    rd_ptr_d      = rd_ptr_q;
    cmp_valid_d   = 1'b0;
    cmp_ptr_d     = cmp_ptr_q;
    res_outcome_d = res_outcome_q;
    res_slot_d    = res_slot_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (complete) begin
          rd_ptr_d = '0;
          if (locked_q) begin
            res_outcome_d = OUT_LOCKED;
            res_slot_d    = '0;
            state_d       = ST_OUT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          res_outcome_d = OUT_DUPLICATE;
          res_slot_d    = cmp_ptr_q;
          state_d       = ST_OUT;
        end else if (rd_ptr_q < count_q) begin
          ram_re      = 1'b1;
          cmp_valid_d = 1'b1;
          cmp_ptr_d   = rd_ptr_q[SLOT_W-1:0];
          rd_ptr_d    = rd_ptr_q + CNT_W'(1);
        end else if (count_q < CNT_W'(TABLE_DEPTH)) begin
          ram_we        = 1'b1;
          res_outcome_d = OUT_STORED;
          res_slot_d    = count_q[SLOT_W-1:0];
          count_d       = count_q + CNT_W'(1);
          state_d       = ST_OUT;
        end else begin
          res_outcome_d = OUT_FULL;
          res_slot_d    = '0;
          state_d       = ST_OUT;
        end
      end
      ST_OUT: begin
        // The assembled tag stays put here, since no byte is taken outside idle.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  tfd_ram #(
    .WIDTH (TAG_W),
    .DEPTH (TABLE_DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[SLOT_W-1:0]),
    .wdata_i ({ah_q, al_q}),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q[SLOT_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fvalid_q    <= 1'b0;
      tags_q      <= '0;
      k_q         <= '0;
      idx_q       <= '0;
      ah_q        <= '0;
      al_q        <= '0;
      state_q     <= ST_IDLE;
      locked_q    <= 1'b0;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      fvalid_q    <= fvalid_d;
      tags_q      <= tags_d;
      k_q         <= k_d;
      idx_q       <= idx_d;
      ah_q        <= ah_d;
      al_q        <= al_d;
      state_q     <= state_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        locked_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    cmp_ptr_q     <= cmp_ptr_d;
    res_outcome_q <= res_outcome_d;
    res_slot_q    <= res_slot_d;
    if (out_load) begin
      out_high_q    <= ah_q;
      out_low_q     <= al_q;
      out_outcome_q <= res_outcome_q;
      out_slot_q    <= res_slot_q;
      out_count_q   <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tag_id_high_o = out_high_q;
  assign tag_id_low_o  = out_low_q;
  assign outcome_o     = out_outcome_q;
  assign slot_index_o  = out_slot_q;
  assign entry_count_o = out_count_q;

  // The table never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // Every write to the tag memory raises the count by exactly one.
  a_write_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("tag write without count update");

  // A freshly stored tag lands in the last occupied slot.
  a_store_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_outcome_q == OUT_STORED)) |->
      (CNT_W'(res_slot_q) + CNT_W'(1) == count_q))
    else $error("stored slot does not match entry count");

  // The scan never reads past the occupied entries.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rd_ptr_q <= count_q))
    else $error("scan pointer beyond entry count");

  // No byte is taken while a completed tag is still being resolved.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete |=> !in_ready_o)
    else $error("input accepted during table scan");

endmodule
